>>> design/ccbd_pkg.sv
// Shared types and constants of the console CPU bus decoder.
package ccbd_pkg;

  // Memory depths; both must be powers of two so that the address mirror is a mask.
  localparam int unsigned WORK_RAM_DEPTH = 2048;
  localparam int unsigned CART_RAM_DEPTH = 8192;
  localparam int unsigned WRAM_AW = $clog2(WORK_RAM_DEPTH);
  localparam int unsigned CRAM_AW = $clog2(CART_RAM_DEPTH);

  localparam logic [15:0] WRAM_LAST   = 16'h1FFF;
  localparam logic [15:0] PIC_LAST    = 16'h3FFF;
  localparam logic [15:0] AUDIO_FIRST = 16'h4000;
  localparam logic [15:0] AUDIO_LAST  = 16'h4013;
  localparam logic [15:0] DMA_ADDR    = 16'h4014;
  localparam logic [15:0] AUDIO_STAT  = 16'h4015;
  localparam logic [15:0] PAD_ADDR    = 16'h4016;
  localparam logic [15:0] AUDIO_FRAME = 16'h4017;
  localparam logic [15:0] CRAM_FIRST  = 16'h6000;
  localparam logic [15:0] CRAM_LAST   = 16'h7FFF;
  localparam logic [15:0] MAPPER_FIRST = 16'h8000;

  typedef enum logic [2:0] {
    TGT_WRAM   = 3'd0,
    TGT_PIC    = 3'd1,
    TGT_AUDIO  = 3'd2,
    TGT_DMA    = 3'd3,
    TGT_PAD    = 3'd4,
    TGT_CRAM   = 3'd5,
    TGT_MAPPER = 3'd6,
    TGT_NONE   = 3'd7
  } target_e;

  // Where the returned byte of a pending access comes from.
  typedef enum logic [1:0] {
    RD_LOCAL = 2'd0,
    RD_WRAM  = 2'd1,
    RD_CRAM  = 2'd2
  } rd_src_e;

  typedef struct packed {
    target_e     target;
    rd_src_e     src;
    logic [7:0]  rdata;
    logic        dma_start;
    logic [7:0]  dma_page;
  } stage_t;

endpackage

>>> design/ccbd_ram.sv
// Generic single-port synchronous RAM with a registered read.
module ccbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/console_cpu_bus_decoder.sv
// Top level of the console CPU bus decoder: address decode, local RAMs and registers.
//
//  Channel  Direction  Handshake                  Payload
//  in       sink       in_valid_i / in_ready_o    command_i, address_i, write_data_i,
//                                                 pad_buttons_i
//  out      source     out_valid_o / out_ready_i  target_o, read_data_o, dma_start_o,
//                                                 dma_page_o
//
// One transfer per clock is sustained on both channels while out_ready_i is high. The
// input transfer issues the RAM access into the middle stage, and the registered RAM
// read data is taken into the output register when the middle stage moves on.
// Reset clears the valid flags, the controller shifter and the DMA page latch; the
// RAM contents are undefined until written.
// When the output stalls, one access waits in the middle stage with the RAM read data
// held, and only then does in_ready_o drop.
module console_cpu_bus_decoder
  import ccbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  pad_buttons_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [7:0]  read_data_o,
  output logic        dma_start_o,
  output logic [7:0]  dma_page_o
);

  logic       in_acc;
  logic       out_move;
  target_e    tgt;
  logic       s1_valid_q, s1_valid_d;
  stage_t     s1_q, s1_d;
  logic       out_valid_q, out_valid_d;
  stage_t     out_q, out_d;
  logic [7:0] pad_q, pad_d;
  logic [7:0] dma_q, dma_d;
  logic       wram_en, cram_en;
  logic [7:0] wram_rdata, cram_rdata;

  // Address decode; the first matching region wins.
  always_comb begin
    priority if (address_i <= WRAM_LAST) begin
      tgt = TGT_WRAM;
    end else if (address_i <= PIC_LAST) begin
      tgt = TGT_PIC;
    end else if ((address_i >= AUDIO_FIRST && address_i <= AUDIO_LAST) ||
                 address_i == AUDIO_STAT || address_i == AUDIO_FRAME) begin
      tgt = TGT_AUDIO;
    end else if (address_i == DMA_ADDR) begin
      tgt = TGT_DMA;
    end else if (address_i == PAD_ADDR) begin
      tgt = TGT_PAD;
    end else if (address_i >= CRAM_FIRST && address_i <= CRAM_LAST) begin
      tgt = TGT_CRAM;
    end else if (address_i >= MAPPER_FIRST) begin
      tgt = TGT_MAPPER;
    end else begin
      tgt = TGT_NONE;
    end
  end

  // The middle stage moves on whenever the output register is empty or being taken.
  assign out_move   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_move;
  assign in_acc     = in_valid_i && in_ready_o;

  // Both RAMs are touched only on an input transfer, so their read data holds
  // while the middle stage is stalled.
  assign wram_en = in_acc && (tgt == TGT_WRAM);
  assign cram_en = in_acc && (tgt == TGT_CRAM);

  ccbd_ram #(
    .Width (8),
    .Depth (WORK_RAM_DEPTH)
  ) u_wram (
    .clk_i   (clk_i),
    .en_i    (wram_en),
    .we_i    (command_i),
    .addr_i  (address_i[WRAM_AW-1:0]),
    .wdata_i (write_data_i),
    .rdata_o (wram_rdata)
  );

  ccbd_ram #(
    .Width (8),
    .Depth (CART_RAM_DEPTH)
  ) u_cram (
    .clk_i   (clk_i),
    .en_i    (cram_en),
    .we_i    (command_i),
    .addr_i  (address_i[CRAM_AW-1:0]),
    .wdata_i (write_data_i),
    .rdata_o (cram_rdata)
  );

  // Local registers and the contents of the middle stage.
  always_comb begin
    pad_d = pad_q;
    dma_d = dma_q;
    s1_d  = '{target: tgt, src: RD_LOCAL, rdata: 8'h00, dma_start: 1'b0, dma_page: dma_q};
    unique case (tgt)
      TGT_WRAM: begin
        if (command_i) begin
          s1_d.rdata = write_data_i;
        end else begin
          s1_d.src = RD_WRAM;
        end
      end
      TGT_CRAM: begin
        if (command_i) begin
          s1_d.rdata = write_data_i;
        end else begin
          s1_d.src = RD_CRAM;
        end
      end
      TGT_DMA: begin
        if (command_i) begin
          dma_d          = write_data_i;
          s1_d.dma_start = 1'b1;
          s1_d.dma_page  = write_data_i;
        end
      end
      TGT_PAD: begin
        if (command_i) begin
          pad_d      = pad_buttons_i;
          s1_d.rdata = pad_buttons_i;
        end else begin
          pad_d      = {pad_q[6:0], 1'b0};
          s1_d.rdata = {7'b0, pad_q[7]};
        end
      end
      default: begin
      end
    endcase
  end

  // The RAM read data is folded in on the way to the output register.
  always_comb begin
    out_d = s1_q;
    unique case (s1_q.src)
      RD_WRAM:  out_d.rdata = wram_rdata;
      RD_CRAM:  out_d.rdata = cram_rdata;
      default:  out_d.rdata = s1_q.rdata;
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_move) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pad_q       <= 8'h00;
      dma_q       <= 8'h00;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        pad_q <= pad_d;
        dma_q <= dma_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (out_move && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign target_o    = out_q.target;
  assign read_data_o = out_q.rdata;
  assign dma_start_o = out_q.dma_start;
  assign dma_page_o  = out_q.dma_page;

  // A full middle stage behind a stalled output must hold off new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages are blocked");

  // A DMA start is only ever reported for the DMA page register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dma_start_o) |-> (target_o == TGT_DMA))
    else $error("dma_start on a target other than the DMA register");

  // Units handled elsewhere always return zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (target_o == TGT_PIC || target_o == TGT_AUDIO ||
                     target_o == TGT_MAPPER || target_o == TGT_NONE))
      |-> (read_data_o == 8'h00))
    else $error("non-zero read data from a remote target");

  // A DMA register write lands in the page latch at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i && address_i == DMA_ADDR) |=> (dma_q == $past(write_data_i)))
    else $error("DMA page latch missed a write");

endmodule
